// File: hw/rtl/ccot_pkg.sv
// Shared constants for the capsule-capsule overlap test unit.
// No dependencies.
package ccot_pkg;
  localparam int T_FRAC   = 16;
  localparam int PROJ_LAT = 21;
  localparam int DIST_W   = 34;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
endpackage

// File: hw/rtl/capsule_capsule_overlap_test_unit.sv
// Top level of the capsule-capsule overlap test unit.
// Depends on ccot_pkg and ccot_proj.
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+----------------------------
//  input    | in_seg*, in_radius*           | start & !busy (busy is 0)
//  result   | out_overlaps, out_closest_... | out_valid strobe, one cycle
//
// One word enters per cycle. Most of the pipeline depth lies in the two
// projection pipelines with their bit-per-stage dividers. Reset clears
// only the valid bits.
// The receiver cannot stall, so the pipeline never holds.
module capsule_capsule_overlap_test_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [47:0] in_seg0_start,
  input  logic [47:0] in_seg0_end,
  input  logic [47:0] in_seg1_start,
  input  logic [47:0] in_seg1_end,
  input  logic [15:0] in_radius0,
  input  logic [15:0] in_radius1,
  output logic        out_valid,
  output logic        out_overlaps,
  output logic [33:0] out_closest_dist_sq
);
  localparam int CB  = COORD_BITS;
  localparam int EW  = CB + 1;
  localparam int DW  = 2 * CB + 4;
  localparam int SW  = (DW > ccot_pkg::DIST_W) ? DW : ccot_pkg::DIST_W;
  localparam int PL  = ccot_pkg::PROJ_LAT;
  localparam int RL  = 2 * PL + 5;

  logic signed [CB-1:0] pin [4][3];
  logic                 v1_r, v2_r, v3_r, v4_r, e1_r, e2_r, o_r;
  logic signed [CB-1:0] p1_r [4][3], p2_r [4][3], p3_r [4][3];
  logic signed [EW-1:0] df_r [4][3];
  logic signed [2*EW-1:0] sq_r [4][3];
  logic [DW-1:0]        d_r [4];
  logic signed [CB-1:0] best0_r [3], a1_r [3], b1_r [3];
  logic [16:0]          rs_r;
  logic [33:0]          rsq_r [RL];
  logic signed [CB-1:0] a0_d [PL+1][3], b0_d [PL+1][3];
  logic signed [CB-1:0] bs1_d [PL][3];
  logic                 pv1, pv2;
  logic signed [CB-1:0] best1 [3], best0f [3];
  logic signed [EW-1:0] ed_r [3];
  logic signed [2*EW-1:0] esq_r [3];
  logic                 ovl_r;
  logic [33:0]          dist_r;
  logic [DW-1:0]        dsum;
  logic [SW-1:0]        dist_x;
  logic                 sel_end;

  assign busy = 1'b0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pin[0][i] = $signed(in_seg0_start[i*CB +: CB]);
      pin[1][i] = $signed(in_seg0_end[i*CB +: CB]);
      pin[2][i] = $signed(in_seg1_start[i*CB +: CB]);
      pin[3][i] = $signed(in_seg1_end[i*CB +: CB]);
    end
    sel_end = (d_r[2] < d_r[0]) || (d_r[2] < d_r[1]) ||
              (d_r[3] < d_r[0]) || (d_r[3] < d_r[1]);
    dsum   = DW'(esq_r[0]) + DW'(esq_r[1]) + DW'(esq_r[2]);
    dist_x = SW'(dsum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      e1_r <= 1'b0;
      e2_r <= 1'b0;
      o_r  <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      e1_r <= pv2;
      e2_r <= e1_r;
      o_r  <= e2_r;
    end
  end

  always_ff @(posedge clk) begin
    rs_r     <= 17'(in_radius0) + 17'(in_radius1);
    rsq_r[0] <= rs_r * rs_r;
    for (int k = 1; k < RL; k++) rsq_r[k] <= rsq_r[k-1];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        p1_r[j][i] <= pin[j][i];
        p2_r[j][i] <= p1_r[j][i];
        p3_r[j][i] <= p2_r[j][i];
      end
      df_r[0][i] <= EW'(pin[2][i]) - EW'(pin[0][i]);
      df_r[1][i] <= EW'(pin[3][i]) - EW'(pin[0][i]);
      df_r[2][i] <= EW'(pin[2][i]) - EW'(pin[1][i]);
      df_r[3][i] <= EW'(pin[3][i]) - EW'(pin[1][i]);
      for (int j = 0; j < 4; j++) sq_r[j][i] <= df_r[j][i] * df_r[j][i];
      best0_r[i] <= sel_end ? p3_r[1][i] : p3_r[0][i];
      a1_r[i]    <= p3_r[2][i];
      b1_r[i]    <= p3_r[3][i];
      a0_d[0][i] <= p3_r[0][i];
      b0_d[0][i] <= p3_r[1][i];
      bs1_d[0][i] <= best1[i];
      for (int k = 1; k <= PL; k++) begin
        a0_d[k][i]  <= a0_d[k-1][i];
        b0_d[k][i]  <= b0_d[k-1][i];
      end
      for (int k = 1; k < PL; k++) begin
        bs1_d[k][i] <= bs1_d[k-1][i];
      end
      ed_r[i]  <= EW'(best0f[i]) - EW'(bs1_d[PL-1][i]);
      esq_r[i] <= ed_r[i] * ed_r[i];
    end
    for (int j = 0; j < 4; j++) begin
      d_r[j] <= DW'(sq_r[j][0]) + DW'(sq_r[j][1]) + DW'(sq_r[j][2]);
    end
    ovl_r  <= dist_x < SW'(rsq_r[RL-1]);
    dist_r <= (dist_x > SW'(ccot_pkg::DIST_MAX)) ? ccot_pkg::DIST_MAX
                                                 : ccot_pkg::DIST_W'(dist_x);
  end

  ccot_proj #(.CB(CB)) u_proj1 (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (v4_r),
    .a_i   (a1_r),
    .b_i   (b1_r),
    .p_i   (best0_r),
    .vld_o (pv1),
    .r_o   (best1)
  );

  ccot_proj #(.CB(CB)) u_proj0 (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (pv1),
    .a_i   (a0_d[PL]),
    .b_i   (b0_d[PL]),
    .p_i   (best1),
    .vld_o (pv2),
    .r_o   (best0f)
  );

  assign out_valid           = o_r;
  assign out_overlaps        = ovl_r;
  assign out_closest_dist_sq = dist_r;
endmodule

// File: hw/rtl/ccot_proj.sv
// Pipelined projection of a point onto a segment with a clamped parameter.
// Bit-per-stage restoring divider for t; depends on ccot_pkg.
module ccot_proj #(
  parameter int CB = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  input  logic signed [CB-1:0] a_i [3],
  input  logic signed [CB-1:0] b_i [3],
  input  logic signed [CB-1:0] p_i [3],
  output logic                 vld_o,
  output logic signed [CB-1:0] r_o [3]
);
  localparam int EW = CB + 1;
  localparam int DW = 2 * CB + 4;
  localparam int TF = ccot_pkg::T_FRAC;
  localparam int NS = TF + 1;

  logic                 v0_r, v1_r, vm_r, vo_r;
  logic signed [EW-1:0] ab0_r [3], pa0_r [3], ab1_r [3];
  logic signed [CB-1:0] a0_r [3], a1_r [3], am_r [3], ro_r [3];
  logic signed [2*EW-1:0] mn_r [3], md_r [3];
  logic signed [EW+17:0]  tp_r [3];
  logic signed [EW-1:0] abd_r [NS][3];
  logic signed [CB-1:0] ad_r [NS][3];
  logic [DW-1:0]        rem_r [NS];
  logic [DW-1:0]        den_r [NS];
  logic [TF-1:0]        q_r [NS];
  logic                 zero_r [NS], full_r [NS], vd_r [NS];

  logic signed [DW-1:0] num_nxt, den_nxt;
  logic [DW:0]          rem2   [NS];
  logic                 ge     [NS];
  logic [TF:0]          t_nxt;
  logic signed [EW+17:0] rnd    [3];
  logic signed [EW+17:0] shf    [3];

  always_comb begin
    num_nxt = DW'(mn_r[0]) + DW'(mn_r[1]) + DW'(mn_r[2]);
    den_nxt = DW'(md_r[0]) + DW'(md_r[1]) + DW'(md_r[2]);
    rem2[0] = '0;
    ge[0]   = 1'b0;
    for (int k = 1; k < NS; k++) begin
      rem2[k] = {rem_r[k-1], 1'b0};
      ge[k]   = rem2[k] >= {1'b0, den_r[k-1]};
    end
    if (zero_r[NS-1]) begin
      t_nxt = '0;
    end else if (full_r[NS-1]) begin
      t_nxt = (TF+1)'(1) << TF;
    end else begin
      t_nxt = {1'b0, q_r[NS-1]};
    end
    for (int i = 0; i < 3; i++) begin
      rnd[i] = tp_r[i] + (EW+18)'(1 << (TF - 1));
      shf[i] = rnd[i] >>> TF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      vm_r <= 1'b0;
      vo_r <= 1'b0;
      for (int k = 0; k < NS; k++) vd_r[k] <= 1'b0;
    end else begin
      v0_r  <= vld_i;
      v1_r  <= v0_r;
      vd_r[0] <= v1_r;
      for (int k = 1; k < NS; k++) vd_r[k] <= vd_r[k-1];
      vm_r  <= vd_r[NS-1];
      vo_r  <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ab0_r[i] <= EW'(b_i[i]) - EW'(a_i[i]);
      pa0_r[i] <= EW'(p_i[i]) - EW'(a_i[i]);
      a0_r[i]  <= a_i[i];
      mn_r[i]  <= pa0_r[i] * ab0_r[i];
      md_r[i]  <= ab0_r[i] * ab0_r[i];
      ab1_r[i] <= ab0_r[i];
      a1_r[i]  <= a0_r[i];
      abd_r[0][i] <= ab1_r[i];
      ad_r[0][i]  <= a1_r[i];
      for (int k = 1; k < NS; k++) begin
        abd_r[k][i] <= abd_r[k-1][i];
        ad_r[k][i]  <= ad_r[k-1][i];
      end
      tp_r[i] <= $signed({1'b0, t_nxt}) * abd_r[NS-1][i];
      am_r[i] <= ad_r[NS-1][i];
      ro_r[i] <= am_r[i] + CB'(shf[i]);
    end
    rem_r[0]  <= num_nxt;
    den_r[0]  <= den_nxt;
    q_r[0]    <= '0;
    zero_r[0] <= (den_nxt == '0) || (num_nxt <= 0);
    full_r[0] <= num_nxt >= den_nxt;
    for (int k = 1; k < NS; k++) begin
      rem_r[k]  <= ge[k] ? DW'(rem2[k] - {1'b0, den_r[k-1]}) : DW'(rem2[k]);
      den_r[k]  <= den_r[k-1];
      q_r[k]    <= {q_r[k-1][TF-2:0], ge[k]};
      zero_r[k] <= zero_r[k-1];
      full_r[k] <= full_r[k-1];
    end
  end

  assign vld_o = vo_r;
  assign r_o   = ro_r;
endmodule

// File: bench/tb_capsule_capsule_overlap_test_unit.sv
// Testbench for the capsule-capsule overlap test unit: drives capsule pairs
// and checks every result word against an in-bench predictor.
// Depends on ccot_pkg and the capsule_capsule_overlap_test_unit RTL.
`timescale 1ns / 100ps

class overlap_scoreboard;
  typedef struct {
    logic        hit;
    logic [33:0] dsq;
  } verdict_t;

  verdict_t pending[$];
  int       mismatches;
  int       checked;

  function longint coord(logic [47:0] p, int axis);
    logic [15:0] raw;
    raw = p[axis*16 +: 16];
    return longint'($signed(raw));
  endfunction

  function longint floor_t(longint v);
    if (v >= 0) return v >>> ccot_pkg::T_FRAC;
    return -(((-v) + 65535) >>> ccot_pkg::T_FRAC);
  endfunction

  function void proj(input longint a[3], input longint b[3], input longint p[3],
                     output longint r[3]);
    longint ab[3];
    longint num, den, t;
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      ab[i] = b[i] - a[i];
      num += (p[i] - a[i]) * ab[i];
      den += ab[i] * ab[i];
    end
    if (den <= 0 || num <= 0) t = 0;
    else if (num >= den) t = 65536;
    else t = (num << ccot_pkg::T_FRAC) / den;
    for (int i = 0; i < 3; i++)
      r[i] = a[i] + floor_t(t * ab[i] + 32768);
  endfunction

  function longint dsq3(longint u[3], longint v[3]);
    longint s;
    s = 0;
    for (int i = 0; i < 3; i++) s += (u[i] - v[i]) * (u[i] - v[i]);
    return s;
  endfunction

  function void note_pair(logic [47:0] s0, logic [47:0] e0, logic [47:0] s1,
                          logic [47:0] e1, logic [15:0] r0, logic [15:0] r1);
    longint a0[3], b0[3], a1[3], b1[3], p0[3], p1[3];
    longint d0, d1, d2, d3, dsum, rs;
    verdict_t v;
    for (int i = 0; i < 3; i++) begin
      a0[i] = coord(s0, i);
      b0[i] = coord(e0, i);
      a1[i] = coord(s1, i);
      b1[i] = coord(e1, i);
    end
    d0 = dsq3(a1, a0);
    d1 = dsq3(b1, a0);
    d2 = dsq3(a1, b0);
    d3 = dsq3(b1, b0);
    if (d2 < d0 || d2 < d1 || d3 < d0 || d3 < d1) p0 = b0;
    else p0 = a0;
    proj(a1, b1, p0, p1);
    proj(a0, b0, p1, p0);
    dsum = dsq3(p0, p1);
    rs = longint'(r0) + longint'(r1);
    v.hit = dsum < rs * rs;
    v.dsq = (dsum > longint'(ccot_pkg::DIST_MAX)) ? ccot_pkg::DIST_MAX : dsum[33:0];
    pending.push_back(v);
  endfunction

  function void check_word(logic hit, logic [33:0] dsq);
    verdict_t v;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word hit=%0b dsq=%0d", hit, dsq);
      return;
    end
    v = pending.pop_front();
    if (v.hit !== hit || v.dsq !== dsq) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected hit=%0b dsq=%0d, got hit=%0b dsq=%0d",
                 v.hit, v.dsq, hit, dsq);
    end
  endfunction
endclass

module tb_capsule_capsule_overlap_test_unit;
  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [47:0] in_seg0_start, in_seg0_end, in_seg1_start, in_seg1_end;
  logic [15:0] in_radius0, in_radius1;
  logic        out_valid;
  logic        out_overlaps;
  logic [33:0] out_closest_dist_sq;

  overlap_scoreboard sb;
  int idle_pct;
  int quiet_cycles;
  int pairs_sent;

  localparam int WATCHDOG = 5000;
  localparam int DRAIN    = 2 * ccot_pkg::PROJ_LAT + 7 + 20;

  capsule_capsule_overlap_test_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_seg0_start(in_seg0_start), .in_seg0_end(in_seg0_end),
    .in_seg1_start(in_seg1_start), .in_seg1_end(in_seg1_end),
    .in_radius0(in_radius0), .in_radius1(in_radius1),
    .out_valid(out_valid), .out_overlaps(out_overlaps),
    .out_closest_dist_sq(out_closest_dist_sq)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_word(out_overlaps, out_closest_dist_sq);
      if ((start && !busy) || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("watchdog expired with %0d results pending", sb.pending.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [47:0] rand_point(int mode);
    logic [47:0] p;
    p = 48'({$urandom, $urandom});
    if (mode == 0) begin
      for (int i = 0; i < 3; i++)
        p[i*16 +: 16] = 16'($signed($urandom_range(0, 4095)) - 2048);
    end
    return p;
  endfunction

  task automatic send_pair(logic [47:0] s0, logic [47:0] e0, logic [47:0] s1,
                           logic [47:0] e1, logic [15:0] r0, logic [15:0] r1);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_seg0_start <= s0;
    in_seg0_end <= e0;
    in_seg1_start <= s1;
    in_seg1_end <= e1;
    in_radius0 <= r0;
    in_radius1 <= r1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_pair(s0, e0, s1, e1, r0, r1);
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [47:0] p, q;
    int mode;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_seg0_start = '0;
    in_seg0_end = '0;
    in_seg1_start = '0;
    in_seg1_end = '0;
    in_radius0 = '0;
    in_radius1 = '0;
    idle_pct = 0;
    quiet_cycles = 0;
    pairs_sent = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    p = {16'h7fff, 16'h7fff, 16'h7fff};
    q = {16'h8000, 16'h8000, 16'h8000};
    send_pair('0, '0, '0, '0, 16'h0000, 16'h0000);
    send_pair('0, '0, '0, '0, 16'h0001, 16'h0000);
    send_pair(p, q, q, p, 16'hffff, 16'hffff);
    send_pair(p, p, q, q, 16'h0100, 16'h0100);
    send_pair(q, q, p, p, 16'hffff, 16'hffff);
    send_pair(q, p, p, q, 16'h0000, 16'hffff);
    send_pair('1, '1, '0, '0, 16'h0001, 16'h0001);
    send_pair(48'h0000_0000_0000, 48'h0000_0000_0400, 48'h0100_0000_0200,
              48'h0100_0000_0600, 16'h0080, 16'h0080);
    send_pair(48'h0000_0000_0000, 48'h0000_0000_0400, 48'h0000_0100_0200,
              48'h0000_0100_0200, 16'h0080, 16'h0080);
    send_pair(48'h0000_0000_0300, 48'h0000_0000_0000, 48'h0000_0000_0500,
              48'h0000_0000_0900, 16'h0100, 16'h0100);
    send_pair(48'h0000_0000_0300, 48'h0000_0000_0000, 48'h0000_0000_fe00,
              48'h0000_0000_fc00, 16'h0100, 16'h0100);
    send_pair(48'hffff_0000_0000, 48'h0000_ffff_0000, 48'h0000_0000_ffff,
              48'h0001_0001_0001, 16'h0001, 16'h0000);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 65 : (ph == 3) ? 10 : 0;
      for (int n = 0; n < 100; n++) begin
        mode = ($urandom_range(0, 3) == 0) ? 1 : 0;
        send_pair(rand_point(mode), rand_point(mode), rand_point(mode), rand_point(mode),
                  16'($urandom), (mode == 0) ? 16'($urandom_range(0, 2047)) : 16'($urandom));
        if (n == 50) wait_drained();
      end
    end
    wait_drained();
    repeat (DRAIN) @(negedge clk);

    $display("run covered %0d capsule pairs, %0d result words checked, %0d mismatches",
             pairs_sent, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
